@@ rtl/cwtg_pkg.sv @@
// Package: shared types, constants and saturation helpers for the CW tone generator.
`timescale 1ns / 1ps
package cwtg_pkg;

    localparam int SHAPE_DEPTH = 256;
    localparam int COUNT_WIDTH = 24;
    localparam int SHAPE_AW    = $clog2(SHAPE_DEPTH);
    localparam int RAMP_W      = SHAPE_AW + 1;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SHAPE = 2'd1;
    localparam logic [1:0] MODE_KEY   = 2'd2;

    localparam logic [2:0] REG_VOLUME   = 3'd0;
    localparam logic [2:0] REG_ROT_RE   = 3'd1;
    localparam logic [2:0] REG_ROT_IM   = 3'd2;
    localparam logic [2:0] REG_IQ_GAIN  = 3'd3;
    localparam logic [2:0] REG_IQ_PHASE = 3'd4;
    localparam logic [2:0] REG_SHAPE_LEN = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_A1, S_A2, S_C1, S_C2, S_ZERO
    } cwtg_state_t;

    typedef enum logic [3:0] {
        DP_NONE, DP_T1, DP_T2, DP_T3, DP_A1, DP_A2, DP_C1, DP_OUT, DP_ZERO
    } cwtg_step_t;

    typedef struct packed {
        cwtg_step_t step;
        logic       shape_we;
        logic       key_load;
    } cwtg_cmd_t;

    typedef struct packed {
        logic active;
    } cwtg_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -36'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] x);
        if (x > 34'sd32767)
            return 16'sh7fff;
        else if (x < -34'sd32768)
            return 16'sh8000;
        else
            return x[15:0];
    endfunction

endpackage

@@ rtl/cwtg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cwtg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/cwtg_dp.sv @@
// Datapath: config registers, oscillator, envelope counters, shape RAM and output arithmetic.
`timescale 1ns / 1ps
module cwtg_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cwtg_pkg::cwtg_cmd_t    cmd,
    output cwtg_pkg::cwtg_status_t status,
    input  logic [7:0]             shape_index,
    input  logic [14:0]            shape_value,
    input  logic [23:0]            key_samples,
    input  logic                   cfg_write,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output logic signed [15:0]     out_real,
    output logic signed [15:0]     out_imag
);
    import cwtg_pkg::*;

    logic [14:0]        volume_reg;
    logic signed [31:0] rot_re_reg, rot_im_reg;
    logic signed [15:0] gain_reg, phase_reg;
    logic [8:0]         shape_len_reg;

    logic signed [31:0]     osc_re_reg, osc_im_reg;
    logic [RAMP_W-1:0]      ramp_reg;
    logic [COUNT_WIDTH-1:0] keyed_reg;

    logic signed [63:0] prod_a_reg, prod_b_reg;
    logic [29:0]        amp_reg;
    logic signed [34:0] tr_reg, ti_reg;
    logic signed [15:0] out_re_reg, out_im_reg;

    logic [RAMP_W-1:0]  len;
    logic               keyed_nz;
    logic [RAMP_W-1:0]  ramp_m1;
    logic [SHAPE_AW-1:0] raddr;
    logic [14:0]        shape_rd;
    logic               ram_we;

    logic signed [34:0] mul_a0, mul_a1;
    logic signed [31:0] mul_b0, mul_b1;
    logic signed [66:0] full0, full1;
    logic signed [65:0] sum_re, sum_im;
    logic signed [63:0] rnd_tr, rnd_ti, rnd_or, rnd_oi;

    assign len = (32'(shape_len_reg) > SHAPE_DEPTH) ? RAMP_W'(SHAPE_DEPTH)
                                                     : RAMP_W'(shape_len_reg);
    assign keyed_nz = (keyed_reg != '0);
    assign ramp_m1  = ramp_reg - RAMP_W'(1);
    assign raddr    = keyed_nz ? ramp_reg[SHAPE_AW-1:0] : ramp_m1[SHAPE_AW-1:0];
    assign status.active = keyed_nz || (ramp_reg != '0);
    assign ram_we = cmd.shape_we && (32'(shape_index) < SHAPE_DEPTH);

    cwtg_ram #(.WIDTH(15), .DEPTH(SHAPE_DEPTH)) u_shape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (SHAPE_AW'(shape_index)),
        .wdata (shape_value),
        .raddr (raddr),
        .rdata (shape_rd)
    );

    // Two multipliers, operands chosen by step
    always_comb
    begin
        mul_a0 = 35'(osc_re_reg);
        mul_a1 = 35'(osc_im_reg);
        mul_b0 = rot_re_reg;
        mul_b1 = rot_im_reg;
        case (cmd.step)
            DP_T2:
            begin
                mul_b0 = rot_im_reg;
                mul_b1 = rot_re_reg;
            end
            DP_A1:
            begin
                mul_b0 = $signed({2'b00, amp_reg});
                mul_b1 = $signed({2'b00, amp_reg});
            end
            DP_C1:
            begin
                mul_a0 = ti_reg;
                mul_a1 = ti_reg;
                mul_b0 = 32'(gain_reg);
                mul_b1 = 32'(phase_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign full0 = mul_a0 * mul_b0;
    assign full1 = mul_a1 * mul_b1;

    // Rotor combine, rounded half up to Q2.30
    assign sum_re = 66'(prod_a_reg) - 66'(prod_b_reg) + 66'sd536870912;
    assign sum_im = 66'(prod_a_reg) + 66'(prod_b_reg) + 66'sd536870912;
    assign rnd_tr = prod_a_reg + 64'sd268435456;
    assign rnd_ti = prod_b_reg + 64'sd268435456;
    assign rnd_or = prod_a_reg + 64'sd536870912;
    assign rnd_oi = (64'(tr_reg) <<< 15) + prod_b_reg + 64'sd1073741824;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg    <= 15'd16384;
            rot_re_reg    <= 32'sh40000000;
            rot_im_reg    <= '0;
            gain_reg      <= 16'sd16384;
            phase_reg     <= '0;
            shape_len_reg <= '0;
            osc_re_reg    <= 32'sh40000000;
            osc_im_reg    <= '0;
            ramp_reg      <= '0;
            keyed_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_VOLUME:    volume_reg    <= cfg_data[14:0];
                    REG_ROT_RE:    rot_re_reg    <= cfg_data;
                    REG_ROT_IM:    rot_im_reg    <= cfg_data;
                    REG_IQ_GAIN:   gain_reg      <= cfg_data[15:0];
                    REG_IQ_PHASE:  phase_reg     <= cfg_data[15:0];
                    REG_SHAPE_LEN: shape_len_reg <= cfg_data[8:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.key_load)
            begin
                keyed_reg <= COUNT_WIDTH'(key_samples);
            end
            case (cmd.step)
                DP_T2:
                begin
                    osc_re_reg <= sat32(sum_re[65:30]);
                    if (keyed_nz)
                    begin
                        if (ramp_reg < len)
                        begin
                            ramp_reg <= ramp_reg + RAMP_W'(1);
                        end
                        keyed_reg <= keyed_reg - COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        ramp_reg <= ramp_m1;
                    end
                end
                DP_T3:
                begin
                    osc_im_reg <= sat32(sum_im[65:30]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.step)
            DP_T1, DP_T2, DP_A1, DP_C1:
            begin
                prod_a_reg <= full0[63:0];
                prod_b_reg <= full1[63:0];
            end
            default:
            begin
            end
        endcase
        case (cmd.step)
            DP_T2:
            begin
                if (keyed_nz && !(ramp_reg < len))
                    amp_reg <= {volume_reg, 15'd0};
                else
                    amp_reg <= 30'(shape_rd) * 30'(volume_reg);
            end
            DP_A2:
            begin
                tr_reg <= rnd_tr[63:29];
                ti_reg <= rnd_ti[63:29];
            end
            DP_OUT:
            begin
                out_re_reg <= sat16(rnd_or[63:30]);
                out_im_reg <= sat16({rnd_oi[63], rnd_oi[63:31]});
            end
            DP_ZERO:
            begin
                out_re_reg <= '0;
                out_im_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_real = out_re_reg;
    assign out_imag = out_im_reg;
endmodule

@@ rtl/cwtg_ctrl.sv @@
// Controller: sequences one item through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module cwtg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             mode,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  cwtg_pkg::cwtg_status_t status,
    output cwtg_pkg::cwtg_cmd_t    cmd
);
    import cwtg_pkg::*;

    cwtg_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept, out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.step       = DP_NONE;
        cmd.shape_we   = accept && (mode == MODE_SHAPE);
        cmd.key_load   = accept && (mode == MODE_KEY);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_TICK)
                    state_next = status.active ? S_T1 : S_ZERO;
            end
            S_T1:
            begin
                cmd.step   = DP_T1;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.step   = DP_T2;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.step   = DP_T3;
                state_next = S_A1;
            end
            S_A1:
            begin
                cmd.step   = DP_A1;
                state_next = S_A2;
            end
            S_A2:
            begin
                cmd.step   = DP_A2;
                state_next = S_C1;
            end
            S_C1:
            begin
                cmd.step   = DP_C1;
                state_next = S_C2;
            end
            S_C2:
            begin
                if (out_free)
                begin
                    cmd.step       = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    cmd.step       = DP_ZERO;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_turn_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_T1 |=> state_reg == S_T2)
        else $error("oscillator turn sequence broken");

    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode == MODE_TICK) |=>
        (state_reg == S_T1 || state_reg == S_ZERO))
        else $error("tick item did not start");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C2 && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == DP_OUT || cmd.step == DP_ZERO) |-> out_free)
        else $error("waiting result overwritten");
endmodule

@@ rtl/cw_keyed_iq_tone_generator_core.sv @@
// Top level: keyed CW I/Q tone generator with envelope shaping and IQ correction.
//
//  Channel  Direction  Handshake               Payload
//  in       sink       in_valid / in_ready     mode, shape_index, shape_value, key_samples
//  out      source     out_valid / out_ready   out_real, out_imag
//  cfg      sink       cfg_write (no wait)     cfg_index, cfg_data
//
// Shape writes, key loads and unused-mode items are handled in the idle state. A tick
// that keys or ramps leaves the idle state for T1, T2 and T3 (the rotor turn on the
// two shared multipliers), A1 and A2 (envelope scaling), C1 (the IQ correction
// products) and C2, which rounds, saturates and loads the output register once the
// output is free. An idle tick (zero output) goes through S_ZERO, which loads zeros
// into the output register once the output is free.
// A new item is taken once the previous one has left the datapath; a result
// waiting on out_ready holds the next result in its final state.
// Reset is asynchronous; the shape RAM is not cleared and must be written.
`timescale 1ns / 1ps
module cw_keyed_iq_tone_generator_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         shape_index,
    input  logic [14:0]        shape_value,
    input  logic [23:0]        key_samples,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_real,
    output logic signed [15:0] out_imag,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import cwtg_pkg::*;

    cwtg_cmd_t    cmd;
    cwtg_status_t status;

    // Sequencer: one item at a time
    cwtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, state and shape table
    cwtg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .shape_index (shape_index),
        .shape_value (shape_value),
        .key_samples (key_samples),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_real    (out_real),
        .out_imag    (out_imag)
    );
endmodule

@@ tb/tb_cw_keyed_iq_tone_generator_core.sv @@
// Testbench for the keyed CW I/Q tone generator core: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

// Scoreboard: carries its own copy of the tone generator state and the expected samples.
class cw_tone_scoreboard;
    int unsigned       volume;
    int unsigned       shape_len;
    longint            rot_re, rot_im, gain, phase;
    longint            osc_re, osc_im;
    int unsigned       ramp;
    longint unsigned   keyed;
    bit [14:0]         shape[256];
    bit                written[256];
    longint            exp_re[$];
    longint            exp_im[$];
    int                errors;
    int                samples_seen;

    function new();
        volume    = 16384;
        rot_re    = longint'(1) << 30;
        rot_im    = 0;
        gain      = 16384;
        phase     = 0;
        shape_len = 0;
        osc_re    = longint'(1) << 30;
        osc_im    = 0;
        ramp      = 0;
        keyed     = 0;
        errors    = 0;
        samples_seen = 0;
        foreach (written[k]) written[k] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            cwtg_pkg::REG_VOLUME:    volume    = d[14:0];
            cwtg_pkg::REG_ROT_RE:    rot_re    = longint'($signed(d));
            cwtg_pkg::REG_ROT_IM:    rot_im    = longint'($signed(d));
            cwtg_pkg::REG_IQ_GAIN:   gain      = longint'($signed(d[15:0]));
            cwtg_pkg::REG_IQ_PHASE:  phase     = longint'($signed(d[15:0]));
            cwtg_pkg::REG_SHAPE_LEN: shape_len = d[8:0];
            default: ;
        endcase
    endfunction

    function longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // round((p1 +/- p2) / 2^30) without forming the 65-bit sum
    function longint round30(longint p1, longint p2, bit neg);
        longint h1, h2, l1, l2, h, l;
        h1 = p1 >>> 30;
        h2 = p2 >>> 30;
        l1 = p1 - (h1 <<< 30);
        l2 = p2 - (h2 <<< 30);
        h  = neg ? h1 - h2 : h1 + h2;
        l  = neg ? l1 - l2 : l1 + l2;
        return clip(h + ((l + (longint'(1) << 29)) >>> 30), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function void rotate();
        longint nr, ni;
        nr = round30(osc_re * rot_re, osc_im * rot_im, 1);
        ni = round30(osc_re * rot_im, osc_im * rot_re, 0);
        osc_re = nr;
        osc_im = ni;
    endfunction

    // Shape entry the next tick will read, or -1
    function int next_shape_read();
        int unsigned len;
        len = shape_len > 256 ? 256 : shape_len;
        if (keyed > 0 && ramp < len) return ramp;
        if (keyed == 0 && ramp > 0) return ramp - 1;
        return -1;
    endfunction

    function void note_item(logic [1:0] m, logic [7:0] idx, logic [14:0] val,
                            logic [23:0] key);
        int unsigned len;
        longint amp, tr, ti;
        len = shape_len > 256 ? 256 : shape_len;
        if (m == cwtg_pkg::MODE_SHAPE)
        begin
            shape[idx]   = val;
            written[idx] = 1;
            return;
        end
        if (m == cwtg_pkg::MODE_KEY)
        begin
            keyed = key;
            return;
        end
        if (m != cwtg_pkg::MODE_TICK) return;
        if (keyed > 0)
        begin
            rotate();
            if (ramp < len)
            begin
                amp = longint'(shape[ramp]) * volume;
                ramp++;
            end
            else
                amp = longint'(volume) * 32768;
            keyed--;
        end
        else if (ramp > 0)
        begin
            rotate();
            ramp--;
            amp = longint'(shape[ramp]) * volume;
        end
        else
        begin
            exp_re.push_back(0);
            exp_im.push_back(0);
            return;
        end
        tr = (osc_re * amp + (longint'(1) << 28)) >>> 29;
        ti = (osc_im * amp + (longint'(1) << 28)) >>> 29;
        exp_re.push_back(clip((ti * gain + (longint'(1) << 29)) >>> 30, -32768, 32767));
        exp_im.push_back(clip((tr * 32768 + ti * phase + (longint'(1) << 30)) >>> 31,
                              -32768, 32767));
    endfunction

    function void check_result(logic signed [15:0] re, logic signed [15:0] im);
        longint er, ei;
        samples_seen++;
        if (exp_re.size() == 0)
        begin
            errors++;
            $error("sample with nothing expected: out_real %0d out_imag %0d", re, im);
            return;
        end
        er = exp_re.pop_front();
        ei = exp_im.pop_front();
        if (longint'(re) != er)
        begin
            errors++;
            $error("out_real: expected %0d, actual %0d", er, re);
        end
        if (longint'(im) != ei)
        begin
            errors++;
            $error("out_imag: expected %0d, actual %0d", ei, im);
        end
    endfunction
endclass

module tb_cw_keyed_iq_tone_generator_core;
    import cwtg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [7:0]         shape_index;
    logic [14:0]        shape_value;
    logic [23:0]        key_samples;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    cw_tone_scoreboard sb = new();

    int  cycles;
    int  items_sent;
    int  ticks_sent;
    int  phases;
    bit  hold_req;   // main asks the receiver for one long hold-off

    cw_keyed_iq_tone_generator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .shape_index (shape_index),
        .shape_value (shape_value),
        .key_samples (key_samples),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_cw_keyed_iq_tone_generator_core: errors");
            $finish;
        end
    end

    // Output side: values read here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_real, out_imag);
    end

    // Receiver stall pattern: runs of always-ready, random and mostly-stalled,
    // plus one long hold-off on request so the core backs up into its input.
    initial
    begin
        int run_left;
        int style;
        int hold_left;
        out_ready = 1'b0;
        run_left  = 0;
        style     = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 300;
                hold_req  = 0;
            end
            if (run_left == 0)
            begin
                run_left = $urandom_range(5, 60);
                style    = $urandom_range(0, 2);
            end
            run_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (style == 0)
                out_ready <= 1'b1;
            else if (style == 1)
                out_ready <= $urandom_range(0, 1);
            else
                out_ready <= ($urandom_range(0, 5) == 0);
        end
    end

    // Present one item and hold it until taken; valid stays high afterwards
    task automatic send_item(input logic [1:0] m, input logic [7:0] idx,
                             input logic [14:0] val, input logic [23:0] key);
        in_valid    <= 1'b1;
        mode        <= m;
        shape_index <= idx;
        shape_value <= val;
        key_samples <= key;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(m, idx, val, key);
        items_sent++;
        if (m == MODE_TICK)
            ticks_sent++;
    endtask

    // Random gap between bursts
    task automatic maybe_pause();
        if ($urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // A tick, preceded by a shape write when it would read an entry never written
    task automatic send_tick();
        int need;
        need = sb.next_shape_read();
        if (need >= 0 && !sb.written[need])
            send_item(MODE_SHAPE, need[7:0], 15'($urandom), 24'($urandom));
        send_item(MODE_TICK, 8'($urandom), 15'($urandom), 24'($urandom));
        maybe_pause();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    // Drop valid at once, wait until every sample is back, then let the datapath empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_re.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h40000000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int n_ticks;
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_TICK;
        shape_index = '0;
        shape_value = '0;
        key_samples = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_VOLUME;
        cfg_data    = '0;
        hold_req    = 0;
        cycles      = 0;
        items_sent  = 0;
        ticks_sent  = 0;
        phases      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, keyed run at full scale, unused mode, shape writes
        send_item(MODE_TICK, 8'd0, 15'd0, 24'd0);
        send_item(MODE_KEY, 8'd0, 15'd0, 24'd3);
        repeat (4) send_tick();
        send_item(2'd3, 8'hff, 15'h7fff, 24'hffffff);
        send_item(MODE_SHAPE, 8'd0, 15'h7fff, 24'd0);
        send_item(MODE_SHAPE, 8'd1, 15'd0, 24'd0);
        send_item(MODE_SHAPE, 8'd255, 15'h7fff, 24'hffffff);
        drain();

        // Directed: short ramp up and down with extreme volume, gain and phase
        write_reg(REG_SHAPE_LEN, 32'd2);
        write_reg(REG_VOLUME, 32'd32767);
        write_reg(REG_IQ_GAIN, 32'h00007fff);
        write_reg(REG_IQ_PHASE, 32'h00008000);
        write_reg(REG_ROT_RE, 32'h2d413ccd);
        write_reg(REG_ROT_IM, 32'h2d413ccd);
        send_item(MODE_KEY, 8'd0, 15'd0, 24'd4);
        repeat (8) send_tick();
        drain();

        // Random phases: new settings, some shape writes, a key load, enough ticks
        // to ramp up, hold and ramp back down
        while (items_sent < 520)
        begin
            phases++;
            write_reg(REG_VOLUME, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'd32767 : 32'd0) : $urandom);
            write_reg(REG_ROT_RE, pick32());
            write_reg(REG_ROT_IM, pick32());
            write_reg(REG_IQ_GAIN, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'h7fff : 32'h8000) : $urandom);
            write_reg(REG_IQ_PHASE, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'h7fff : 32'h8000) : $urandom);
            case ($urandom_range(0, 9))
                0: write_reg(REG_SHAPE_LEN, 32'd0);
                1: write_reg(REG_SHAPE_LEN, 32'd256);
                2: write_reg(REG_SHAPE_LEN, 32'd511);
                default: write_reg(REG_SHAPE_LEN, $urandom_range(1, 12));
            endcase
            repeat ($urandom_range(0, 6))
            begin
                send_item(MODE_SHAPE, 8'($urandom), 15'($urandom), 24'($urandom));
                maybe_pause();
            end
            if ($urandom_range(0, 9) == 0)
                send_item(2'd3, 8'($urandom), 15'($urandom), 24'($urandom));
            // Mostly short keyed runs; the odd one with a wide random count
            if ($urandom_range(0, 7) == 0)
                send_item(MODE_KEY, 8'($urandom), 15'($urandom), 24'($urandom));
            else
                send_item(MODE_KEY, 8'($urandom), 15'($urandom),
                          24'($urandom_range(0, 30)));
            if (phases == 3)
                hold_req = 1;
            n_ticks = sb.keyed > 40 ? 40 : int'(sb.keyed);
            n_ticks += (sb.shape_len > 12 ? 12 : int'(sb.shape_len)) * 2
                       + $urandom_range(0, 4);
            for (k = 0; k < n_ticks; k++)
            begin
                // An occasional re-key in the middle of a ramp
                if ($urandom_range(0, 29) == 0)
                    send_item(MODE_KEY, 8'($urandom), 15'($urandom),
                              24'($urandom_range(0, 8)));
                send_tick();
            end
            drain();
        end

        if (sb.exp_re.size() != 0)
        begin
            sb.errors++;
            $error("%0d expected samples never arrived", sb.exp_re.size());
        end
        $display("Covered %0d items (%0d ticks) over %0d random phases; %0d samples checked.",
                 items_sent, ticks_sent, phases, sb.samples_seen);
        if (sb.errors == 0)
            $display("tb_cw_keyed_iq_tone_generator_core: clean");
        else
            $display("tb_cw_keyed_iq_tone_generator_core: errors");
        $finish;
    end
endmodule
